// ----- design/lev_pkg.sv -----
`timescale 1ns / 1ps

package lev_pkg;

  localparam int MAX_LEN = 64;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int OP_W    = 2;
  localparam int CHAR_W  = 8;
  localparam int DIST_W  = 7;

  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_PROC = 2'd1;
  localparam logic [OP_W-1:0] OP_END  = 2'd2;

  typedef logic [LEN_W-1:0] len_t;

endpackage

// ----- design/levenshtein_edit_distance_top.sv -----
// a first-string word holds the input off while its row is updated, one row
// entry per cycle through one cost cell; the result is registered when the end
// word is taken. the output register holds a result until taken.
// synchronous active-high reset clears lengths, overflow and control state;
// the string store and row memory are not cleared.
`timescale 1ns / 1ps

module levenshtein_edit_distance_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [lev_pkg::OP_W-1:0]   operation,
  input  logic [lev_pkg::CHAR_W-1:0] char_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [lev_pkg::DIST_W-1:0] distance,
  output logic                       overflow
);
  import lev_pkg::*;

  logic [CHAR_W-1:0] str_mem [MAX_LEN];
  len_t              dp_mem  [MAX_LEN];

  len_t              len1;
  len_t              len2;
  logic              ovf;
  logic              busy;
  logic              pend;
  len_t              rd_idx;
  logic [ADDR_W-1:0] wr_addr;
  logic [CHAR_W-1:0] c_reg;
  logic              first_pass;
  len_t              diag;
  len_t              left;
  len_t              tail;
  logic [CHAR_W-1:0] str_rd;
  len_t              up_rd;

  logic              accept;
  logic              issue;
  logic              last_wr;
  logic              str_we;
  len_t              up_val;
  len_t              new_val;

  assign in_ready = !busy && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign issue    = busy && (rd_idx < len2);
  assign last_wr  = pend && (len_t'(wr_addr) + len_t'(1) == len2);
  assign str_we   = accept && (operation == OP_LOAD) && (len1 == '0)
                    && (len2 < len_t'(MAX_LEN));
  assign up_val   = first_pass ? len_t'(wr_addr) + len_t'(1) : up_rd;

  lev_cell u_cell (
    .up   (up_val),
    .left (left),
    .diag (diag),
    .match(str_rd == c_reg),
    .cost (new_val)
  );

  // string store and row memory
  always_ff @(posedge clk) begin
    if (str_we) begin
      str_mem[len2[ADDR_W-1:0]] <= char_value;
    end
    if (issue) begin
      str_rd <= str_mem[rd_idx[ADDR_W-1:0]];
      up_rd  <= dp_mem[rd_idx[ADDR_W-1:0]];
    end
    if (pend) begin
      dp_mem[wr_addr] <= new_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len1      <= '0;
      len2      <= '0;
      ovf       <= 1'b0;
      busy      <= 1'b0;
      pend      <= 1'b0;
      rd_idx    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !(accept && operation == OP_END)) begin
        out_valid <= 1'b0;
      end
      pend <= issue;
      if (issue) begin
        wr_addr <= rd_idx[ADDR_W-1:0];
        rd_idx  <= rd_idx + len_t'(1);
      end
      if (pend) begin
        left <= new_val;
        diag <= up_val;
      end
      if (last_wr) begin
        busy <= 1'b0;
        tail <= new_val;
      end
      if (accept) begin
        case (operation)
          OP_LOAD: begin
            if (len1 == '0) begin
              if (len2 < len_t'(MAX_LEN)) begin
                len2 <= len2 + len_t'(1);
              end else begin
                ovf <= 1'b1;
              end
            end
          end
          OP_PROC: begin
            if (len1 < len_t'(MAX_LEN)) begin
              len1       <= len1 + len_t'(1);
              diag       <= len1;
              left       <= len1 + len_t'(1);
              c_reg      <= char_value;
              first_pass <= (len1 == '0);
              rd_idx     <= '0;
              if (len2 != '0) begin
                busy <= 1'b1;
              end else begin
                tail <= len1 + len_t'(1);
              end
            end else begin
              ovf <= 1'b1;
            end
          end
          OP_END: begin
            out_valid <= 1'b1;
            distance  <= DIST_W'((len1 == '0) ? len2 : tail);
            overflow  <= ovf;
            len1      <= '0;
            len2      <= '0;
            ovf       <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ready)
    else $error("input taken while row update runs");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    pend |-> (len_t'(wr_addr) < len2))
    else $error("row write beyond second string length");

  a_lengths_bounded: assert property (@(posedge clk) disable iff (rst)
    (len1 <= len_t'(MAX_LEN)) && (len2 <= len_t'(MAX_LEN)))
    else $error("string length beyond limit");

  a_row_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && operation == OP_PROC && len1 < len_t'(MAX_LEN) && len2 != '0)
    |=> busy && pend == 1'b0)
    else $error("row update did not start");

  a_issue_while_busy: assert property (@(posedge clk) disable iff (rst)
    pend |-> $past(busy))
    else $error("row write without row update");

endmodule

// ----- design/lev_cell.sv -----
`timescale 1ns / 1ps

module lev_cell (
  input  lev_pkg::len_t up,
  input  lev_pkg::len_t left,
  input  lev_pkg::len_t diag,
  input  logic          match,
  output lev_pkg::len_t cost
);
  import lev_pkg::*;

  len_t del_cost;
  len_t ins_cost;
  len_t sub_cost;
  len_t min_a;

  assign del_cost = up + len_t'(1);
  assign ins_cost = left + len_t'(1);
  assign sub_cost = diag + (match ? len_t'(0) : len_t'(1));
  assign min_a    = (del_cost < ins_cost) ? del_cost : ins_cost;
  assign cost     = (min_a < sub_cost) ? min_a : sub_cost;

endmodule

// ----- test/tb_levenshtein_edit_distance_top.sv -----
`timescale 1ns / 1ps

module tb_levenshtein_edit_distance_top;
  import lev_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_CYCLES = 2 * (MAX_LEN + 1) + 20;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
  } edit_word_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } edit_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     operation = OP_LOAD;
  logic [CHAR_W-1:0]   char_value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [DIST_W-1:0]   distance;
  logic                overflow;

  edit_word_t   pending_words[$];
  edit_result_t distance_expect[$];

  int total_words = 0;
  int counted_words = 0;
  int accepted_words = 0;
  int fail_count = 0;
  int hold_cnt = 0;
  bit hold_done = 1'b0;
  int in_idle_pct;
  int out_idle_pct;

  // predictor state
  logic [CHAR_W-1:0] target_bytes [0:MAX_LEN-1];
  int                edit_row [0:MAX_LEN];
  int                target_len = 0;
  int                source_len = 0;
  bit                dropped_seen = 1'b0;

  levenshtein_edit_distance_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .char_value(char_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .distance  (distance),
    .overflow  (overflow)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // idling phases follow progress through the stimulus
  assign in_idle_pct  = (accepted_words < total_words / 3)     ? 37 :
                        (accepted_words < 2 * total_words / 3) ? 85 : 0;
  assign out_idle_pct = (accepted_words < total_words / 3)     ? 85 :
                        (accepted_words < 2 * total_words / 3) ? 37 : 0;

  function automatic void predict_word(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch);
    int j;
    int diag;
    int up;
    int best;
    edit_result_t res;
    case (op)
      OP_LOAD: begin
        if (source_len == 0) begin
          if (target_len >= MAX_LEN) begin
            dropped_seen = 1'b1;
          end else begin
            target_bytes[target_len] = ch;
            target_len++;
          end
        end
      end
      OP_PROC: begin
        if (source_len >= MAX_LEN) begin
          dropped_seen = 1'b1;
        end else begin
          if (source_len == 0) begin
            for (j = 0; j <= target_len; j++) edit_row[j] = j;
          end
          source_len++;
          diag = edit_row[0];
          edit_row[0] = source_len;
          for (j = 1; j <= target_len; j++) begin
            up = edit_row[j];
            best = diag + ((target_bytes[j-1] == ch) ? 0 : 1);
            if (up + 1 < best) best = up + 1;
            if (edit_row[j-1] + 1 < best) best = edit_row[j-1] + 1;
            edit_row[j] = best;
            diag = up;
          end
        end
      end
      OP_END: begin
        res.distance = DIST_W'((source_len == 0) ? target_len : edit_row[target_len]);
        res.overflow = dropped_seen;
        distance_expect = {distance_expect, res};
        target_len = 0;
        source_len = 0;
        dropped_seen = 1'b0;
      end
      default: ;
    endcase
  endfunction

  task automatic add_word(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch);
    edit_word_t w;
    w.op = op;
    w.ch = ch;
    pending_words = {pending_words, w};
    if (op != OP_UNUSED) counted_words++;
  endtask

  function automatic logic [CHAR_W-1:0] pick_char(bit wide);
    if (wide) return CHAR_W'($urandom_range(255));
    return 8'h61 + CHAR_W'($urandom_range(3));
  endfunction

  // one job with random content, stray unused words and optional late loads
  task automatic add_job(int n2, int n1, bit late);
    int i;
    bit wide;
    wide = ($urandom_range(3) == 0);
    for (i = 0; i < n2; i++) begin
      if ($urandom_range(99) < 3) add_word(OP_UNUSED, CHAR_W'($urandom_range(255)));
      add_word(OP_LOAD, pick_char(wide));
    end
    for (i = 0; i < n1; i++) begin
      if ($urandom_range(99) < 3) add_word(OP_UNUSED, CHAR_W'($urandom_range(255)));
      add_word(OP_PROC, pick_char(wide));
      if (late && i == 0) add_word(OP_LOAD, pick_char(wide));
    end
    add_word(OP_END, CHAR_W'($urandom_range(255)));
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        predict_word(operation, char_value);
        accepted_words <= accepted_words + 1;
      end
      if (pending_words.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        in_valid   <= 1'b1;
        operation  <= pending_words[0].op;
        char_value <= pending_words[0].ch;
        void'(pending_words.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off so the block backs up and stalls its input
  always @(posedge clk) begin
    if (rst) begin
      hold_cnt <= 0;
    end else if (!hold_done && accepted_words >= 150) begin
      hold_cnt  <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (hold_cnt == 0) && ($urandom_range(99) >= out_idle_pct);
    end
  end

  // result check
  always @(posedge clk) begin
    edit_result_t exp_res;
    if (!rst && out_valid && out_ready) begin
      if (distance_expect.size() == 0) begin
        $error("unexpected result word: distance %0d overflow %0d", distance, overflow);
        fail_count++;
      end else begin
        exp_res = distance_expect.pop_front();
        if (distance !== exp_res.distance) begin
          $error("distance mismatch: expected %0d, got %0d", exp_res.distance, distance);
          fail_count++;
        end
        if (overflow !== exp_res.overflow) begin
          $error("overflow mismatch: expected %0d, got %0d", exp_res.overflow, overflow);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int r;
    // both strings empty
    add_word(OP_END, 8'h00);
    // first string empty
    add_word(OP_LOAD, 8'h61);
    add_word(OP_LOAD, 8'h62);
    add_word(OP_END, 8'hff);
    // second string empty
    add_word(OP_PROC, 8'h78);
    add_word(OP_END, 8'h00);
    // byte extremes, swapped order
    add_word(OP_LOAD, 8'h00);
    add_word(OP_LOAD, 8'hff);
    add_word(OP_PROC, 8'hff);
    add_word(OP_PROC, 8'h00);
    add_word(OP_END, 8'h55);
    // late load is ignored, unused operation is ignored
    add_word(OP_LOAD, 8'h61);
    add_word(OP_PROC, 8'h61);
    add_word(OP_LOAD, 8'h62);
    add_word(OP_UNUSED, 8'ha5);
    add_word(OP_UNUSED, 8'h5a);
    add_word(OP_END, 8'h00);
    // identical strings
    add_word(OP_LOAD, 8'h6b);
    add_word(OP_LOAD, 8'h6b);
    add_word(OP_PROC, 8'h6b);
    add_word(OP_PROC, 8'h6b);
    add_word(OP_END, 8'h00);

    // full-length and overlong strings
    add_job(MAX_LEN, MAX_LEN, 1'b0);
    add_job(MAX_LEN + 6, 3, 1'b0);
    add_job(5, MAX_LEN + 4, 1'b0);

    while (counted_words < 600) begin
      r = $urandom_range(99);
      if (r < 2)
        add_job(MAX_LEN - 2 + $urandom_range(5), $urandom_range(4), 1'b0);
      else if (r < 8)
        add_job($urandom_range(8), $urandom_range(8), 1'b1);
      else if (r < 12)
        add_word(OP_END, CHAR_W'($urandom_range(255)));
      else
        add_job($urandom_range(8), $urandom_range(8), 1'b0);
    end
    total_words = pending_words.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    while (distance_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
